@@ sv/rac_pkg.sv @@
// ----------------------------------------------------------------------------
// rac_pkg
// shared constants and types for the region access checker: slot count,
// counter width, region write data and the lookup token that walks the cells
// ----------------------------------------------------------------------------
package rac_pkg;

    localparam int REGION_SLOTS = 8;
    localparam int CNT_W        = $clog2(REGION_SLOTS + 1);
    localparam int ADDR_W       = 32;
    localparam int PERM_W       = 3;
    localparam int USE_W        = 4;

    typedef enum logic
    {
        FUNC_ADD   = 1'b0,
        FUNC_CHECK = 1'b1
    } rac_func_t;

    // region written into one cell
    typedef struct packed
    {
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] region_size;
        logic [PERM_W-1:0] perm;
    } rac_region_t;

    // lookup token handed from cell to cell
    typedef struct packed
    {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [PERM_W-1:0] req;
        logic [CNT_W-1:0]  remaining;
        logic              hit;
        logic              grant;
    } rac_token_t;

endpackage

@@ sv/rac_cell.sv @@
// ----------------------------------------------------------------------------
// rac_cell
// one region slot: holds start, 33-bit end and permission mask, and moves the
// lookup token one step down the chain each cycle
// ----------------------------------------------------------------------------
module rac_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  rac_pkg::rac_region_t wr_data,
    input  rac_pkg::rac_token_t  tok_in,
    output rac_pkg::rac_token_t  tok_out
);
    import rac_pkg::*;

    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W:0]   end_reg;
    logic [PERM_W-1:0] perm_reg;
    rac_token_t        tok_reg;
    rac_token_t        tok_next;

    logic active;
    logic in_range;
    logic match;

    // region storage, end formed at 33 bits so it never wraps
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_reg <= wr_data.address;
            end_reg   <= {1'b0, wr_data.address} + {1'b0, wr_data.region_size};
            perm_reg  <= wr_data.perm;
        end
    end

    always_comb
    begin
        active   = (tok_in.remaining != '0);
        in_range = (tok_in.address >= start_reg) && ({1'b0, tok_in.address} < end_reg);
        match    = tok_in.valid && active && !tok_in.hit && in_range;
        tok_next = tok_in;
        if (active)
        begin
            tok_next.remaining = tok_in.remaining - CNT_W'(1);
        end
        if (match)
        begin
            tok_next.hit   = 1'b1;
            tok_next.grant = ((perm_reg & tok_in.req) == tok_in.req);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ sv/region_access_checker.sv @@
// ----------------------------------------------------------------------------
// region_access_checker
// protection region table built as a chain of slot cells
// ----------------------------------------------------------------------------
// usage
//   a command is taken on a rising edge with start high and busy low; func
//   selects add (store address / region_size / perm_bits in the next free
//   slot) or check (look up address against the stored regions and compare
//   perm_bits as the required mask)
//   every command gives one result, shown for one cycle with done high:
//   access_granted, region_added and regions_in_use
// command flow
//   add: result in the cycle after the transfer, next command may follow
//   at once
//   check: a lookup token enters the first cell and moves one cell per cycle
//   down the chain of REGION_SLOTS cells; the result is registered from the
//   token as it leaves the last cell, and busy is high while the token is in
//   the chain, so a new command waits until the token has left the chain
//   the chain length sets how long a check takes
// reset
//   rst_n clears the region count and the chain; slot contents are not
//   cleared, a slot is only looked at once it has been written
// result side
//   the receiver cannot stall: done is a single-cycle strobe
// ----------------------------------------------------------------------------
module region_access_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       func,
    input  logic [rac_pkg::ADDR_W-1:0] address,
    input  logic [rac_pkg::ADDR_W-1:0] region_size,
    input  logic [rac_pkg::PERM_W-1:0] perm_bits,
    output logic                       done,
    output logic                       access_granted,
    output logic                       region_added,
    output logic [rac_pkg::USE_W-1:0]  regions_in_use
);
    import rac_pkg::*;

    // tok[i] feeds cell i, tok[REGION_SLOTS] leaves the last cell
    rac_token_t             tok [REGION_SLOTS+1];
    logic [REGION_SLOTS-1:0] tok_valid;
    logic [REGION_SLOTS-1:0] wr_en;
    rac_region_t            wr_data;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   done_reg;
    logic                   granted_reg;
    logic                   added_reg;
    logic [USE_W-1:0]       use_reg;

    logic                   accept;
    logic                   is_add;
    logic                   is_check;
    logic                   has_room;
    logic [CNT_W+USE_W-1:0] count_wide;

    // a command transfer
    assign accept   = start && !busy;
    assign is_add   = accept && (rac_func_t'(func) == FUNC_ADD);
    assign is_check = accept && (rac_func_t'(func) == FUNC_CHECK);
    assign has_room = (count_reg < CNT_W'(REGION_SLOTS));

    assign wr_data.address     = address;
    assign wr_data.region_size = region_size;
    assign wr_data.perm        = perm_bits;

    // token entering the first cell: check only the slots in use
    assign tok[0].valid     = is_check;
    assign tok[0].address   = address;
    assign tok[0].req       = perm_bits;
    assign tok[0].remaining = count_reg;
    assign tok[0].hit       = 1'b0;
    assign tok[0].grant     = 1'b0;

    for (genvar i = 0; i < REGION_SLOTS; i++)
    begin : g_cell
        // the add writes the slot just past the filled ones
        assign wr_en[i] = is_add && has_room && (count_reg == CNT_W'(i));

        rac_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en[i]),
            .wr_data (wr_data),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );

        assign tok_valid[i] = tok[i+1].valid;
    end

    // no new command while a lookup is in the chain
    assign busy = |tok_valid;

    assign count_next = (is_add && has_room) ? count_reg + CNT_W'(1) : count_reg;
    assign count_wide = {{USE_W{1'b0}}, count_next};

    // result register and region count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            done_reg    <= 1'b0;
            granted_reg <= 1'b0;
            added_reg   <= 1'b0;
            use_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= is_add || tok[REGION_SLOTS].valid;
            if (is_add)
            begin
                granted_reg <= 1'b0;
                added_reg   <= has_room;
                use_reg     <= count_wide[USE_W-1:0];
            end
            else if (tok[REGION_SLOTS].valid)
            begin
                // no hit leaves grant low: access denied
                granted_reg <= tok[REGION_SLOTS].hit && tok[REGION_SLOTS].grant;
                added_reg   <= 1'b0;
                use_reg     <= count_wide[USE_W-1:0];
            end
        end
    end

    assign done           = done_reg;
    assign access_granted = granted_reg;
    assign region_added   = added_reg;
    assign regions_in_use = use_reg;

    // only one lookup at a time in the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid))
        else $error("more than one lookup token in the chain");

    // count never runs past the slot total
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(REGION_SLOTS))
        else $error("region count above slot total");

    // an add always answers in the next cycle
    a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
        is_add |=> done)
        else $error("add gave no result");

    // a stored add bumps the count by one
    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (is_add && has_room) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("add did not advance region count");

    // a result is never both a grant and an add
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(access_granted && region_added))
        else $error("result marked as both grant and add");

endmodule
